/* rtl/kgt_pkg.sv */
package kgt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 64;
    localparam int GAIN_W      = 16;
    localparam int TIME_W      = 64;
    localparam int OCC_W       = 5;
    localparam int GEN_W       = 32;
    localparam int CMD_W       = 2;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(16384);
    localparam logic [GEN_W-1:0]  GEN_RESET  = GEN_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE   = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_LOOKUP   = 2'd2,
        CMD_SNAPSHOT = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [GAIN_W-1:0] gain;
        logic              mute;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic             clr;
        logic [IDX_W-1:0] idx;
        t_entry           data;
    } t_wr;

    typedef struct packed {
        logic match;
        logic older;
    } t_cmp;

endpackage

/* rtl/keyed_gain_table_lru_replace.sv */
// Keyed gain table: 16 entries of {key, gain, mute, time}, replaced by oldest time.
// Request channel: i_in_valid / o_in_ready carry command, key, gain, mute, now.
// Result channel: o_out_valid / i_out_ready carry ok, entry fields, occupied and
// change counts, and last.
// One request is worked at a time; o_in_ready is high only while the sequencer idles.
// Update, remove and lookup with a nonzero key walk all entries through one shared
// compare unit, one entry per cycle, then act: the result is registered in the act
// step, which waits for a free output register, and the block takes a new request
// the cycle after that act. A zero key or an empty snapshot skips the walk and goes
// straight to the act step, with ok low.
// Snapshot reads one entry index per cycle, holding while an occupied entry waits for
// a free output register, and emits each occupied entry as it is reached.
// The single output register holds a result until taken; a stalled receiver freezes
// the act step, or holds the snapshot walk at an occupied entry; nothing is dropped.
// Reset (synchronous, active low) empties the table through per-entry valid
// bits at once, sets the occupied count to 0 and the change counter to 1.
module keyed_gain_table_lru_replace (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [kgt_pkg::CMD_W-1:0]       i_command,
    input  logic [kgt_pkg::KEY_W-1:0]       i_key,
    input  logic [kgt_pkg::GAIN_W-1:0]      i_gain,
    input  logic                            i_mute,
    input  logic [kgt_pkg::TIME_W-1:0]      i_now,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_ok,
    output logic [kgt_pkg::KEY_W-1:0]       o_entry_key,
    output logic [kgt_pkg::GAIN_W-1:0]      o_entry_gain,
    output logic                            o_entry_mute,
    output logic [kgt_pkg::TIME_W-1:0]      o_entry_time,
    output logic [kgt_pkg::OCC_W-1:0]       o_occupied_count,
    output logic [kgt_pkg::GEN_W-1:0]       o_change_count,
    output logic                            o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SNAP,
        S_ACT
    } t_state;

    localparam logic [kgt_pkg::IDX_W-1:0] LAST_IDX = kgt_pkg::IDX_W'(kgt_pkg::TABLE_DEPTH - 1);

    t_state r_state, n_state;
    logic [kgt_pkg::IDX_W-1:0]  r_idx, n_idx;
    kgt_pkg::t_cmd              r_cmd, n_cmd;
    logic [kgt_pkg::KEY_W-1:0]  r_key, n_key;
    logic [kgt_pkg::GAIN_W-1:0] r_gain, n_gain;
    logic                       r_mute, n_mute;
    logic [kgt_pkg::TIME_W-1:0] r_now, n_now;
    logic                       r_nop, n_nop;
    logic                       r_hit, n_hit;
    logic [kgt_pkg::IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic                       r_free, n_free;
    logic [kgt_pkg::IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [kgt_pkg::IDX_W-1:0]  r_old_idx, n_old_idx;
    logic [kgt_pkg::TIME_W-1:0] r_old_time, n_old_time;
    logic [kgt_pkg::CNT_W-1:0]  r_count, n_count;
    logic [kgt_pkg::GEN_W-1:0]  r_gen, n_gen;

    logic                       r_out_valid, n_out_valid;
    logic                       r_ok, n_ok;
    kgt_pkg::t_entry            r_out_entry, n_out_entry;
    logic [kgt_pkg::OCC_W-1:0]  r_occ, n_occ;
    logic [kgt_pkg::GEN_W-1:0]  r_chg, n_chg;
    logic                       r_last, n_last;

    kgt_pkg::t_wr               wr;
    logic [kgt_pkg::IDX_W-1:0]  rd_idx;
    kgt_pkg::t_entry            rd_entry;
    logic                       rd_valid;
    logic [kgt_pkg::TABLE_DEPTH-1:0] valid_vec;
    kgt_pkg::t_cmp              cmp;
    logic                       out_free;
    logic                       has_higher;

    assign rd_idx = (r_state == S_ACT) ? r_hit_idx : r_idx;

    kgt_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_rd_idx   (rd_idx),
        .o_rd       (rd_entry),
        .o_rd_valid (rd_valid),
        .o_valid    (valid_vec)
    );

    kgt_cmp u_cmp (
        .i_entry       (rd_entry),
        .i_entry_valid (rd_valid),
        .i_key         (r_key),
        .i_best_time   (r_old_time),
        .o_res         (cmp)
    );

    assign out_free = !r_out_valid || i_out_ready;

    // any occupied entry beyond the current snapshot index
    always_comb begin
        has_higher = 1'b0;
        for (int j = 0; j < kgt_pkg::TABLE_DEPTH; j++) begin
            if (valid_vec[j] && (kgt_pkg::IDX_W'(j) > r_idx)) begin
                has_higher = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_gain      = r_gain;
        n_mute      = r_mute;
        n_now       = r_now;
        n_nop       = r_nop;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_old_idx   = r_old_idx;
        n_old_time  = r_old_time;
        n_count     = r_count;
        n_gen       = r_gen;
        n_out_valid = r_out_valid;
        n_ok        = r_ok;
        n_out_entry = r_out_entry;
        n_occ       = r_occ;
        n_chg       = r_chg;
        n_last      = r_last;
        wr          = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd  = kgt_pkg::t_cmd'(i_command);
                    n_key  = i_key;
                    n_gain = i_gain;
                    n_mute = i_mute;
                    n_now  = i_now;
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    if (kgt_pkg::t_cmd'(i_command) == kgt_pkg::CMD_SNAPSHOT) begin
                        n_nop   = (valid_vec == '0);
                        n_state = (valid_vec == '0) ? S_ACT : S_SNAP;
                    end else begin
                        n_nop   = (i_key == '0);
                        n_state = (i_key == '0) ? S_ACT : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (cmp.match && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end
                if (!rd_valid && !r_free) begin
                    n_free     = 1'b1;
                    n_free_idx = r_idx;
                end
                // strict compare keeps the lowest index on a tie
                if ((r_idx == '0) || cmp.older) begin
                    n_old_idx  = r_idx;
                    n_old_time = rd_entry.stamp;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_ACT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SNAP: begin
                if (!rd_valid) begin
                    n_idx = r_idx + 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_ok        = 1'b1;
                    n_out_entry = rd_entry;
                    n_occ       = kgt_pkg::OCC_W'(r_count);
                    n_chg       = r_gen;
                    n_last      = !has_higher;
                    if (has_higher) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ACT: begin
                if (out_free) begin
                    n_ok        = 1'b0;
                    n_out_entry = '0;
                    if (!r_nop) begin
                        unique case (r_cmd)
                            kgt_pkg::CMD_UPDATE: begin
                                wr.en         = 1'b1;
                                wr.data.key   = r_key;
                                wr.data.gain  = r_gain;
                                wr.data.mute  = r_mute;
                                wr.data.stamp = r_now;
                                if (r_hit) begin
                                    wr.idx = r_hit_idx;
                                end else if (r_free) begin
                                    wr.idx  = r_free_idx;
                                    n_count = r_count + 1'b1;
                                end else begin
                                    wr.idx = r_old_idx;
                                end
                                n_gen = r_gen + 1'b1;
                                n_ok  = 1'b1;
                            end
                            kgt_pkg::CMD_REMOVE: begin
                                if (r_hit) begin
                                    wr.clr = 1'b1;
                                    wr.idx = r_hit_idx;
                                    if (r_count != '0) begin
                                        n_count = r_count - 1'b1;
                                    end
                                    n_gen = r_gen + 1'b1;
                                    n_ok  = 1'b1;
                                end
                            end
                            kgt_pkg::CMD_LOOKUP: begin
                                n_ok = r_hit;
                                if (r_hit) begin
                                    n_out_entry = rd_entry;
                                end
                            end
                            default: begin
                                n_ok = 1'b0;
                            end
                        endcase
                    end
                    n_out_valid = 1'b1;
                    n_occ       = kgt_pkg::OCC_W'(n_count);
                    n_chg       = n_gen;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_gen       <= kgt_pkg::GEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_gain      <= n_gain;
        r_mute      <= n_mute;
        r_now       <= n_now;
        r_nop       <= n_nop;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_old_idx   <= n_old_idx;
        r_old_time  <= n_old_time;
        r_ok        <= n_ok;
        r_out_entry <= n_out_entry;
        r_occ       <= n_occ;
        r_chg       <= n_chg;
        r_last      <= n_last;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_ok             = r_ok;
    assign o_entry_key      = r_out_entry.key;
    assign o_entry_gain     = r_out_entry.gain;
    assign o_entry_mute     = r_out_entry.mute;
    assign o_entry_time     = r_out_entry.stamp;
    assign o_occupied_count = r_occ;
    assign o_change_count   = r_chg;
    assign o_last           = r_last;

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state != S_IDLE)
        else $error("sequencer still idle after taking a request");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == kgt_pkg::CNT_W'($countones(valid_vec)))
        else $error("occupied count out of step with valid bits");

    a_gen_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != $past(r_gen) |-> r_gen == $past(r_gen) + 1'b1)
        else $error("change counter moved by more than one");

    a_table_write_only_in_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.en || wr.clr) |-> (r_state == S_ACT) && out_free)
        else $error("table written outside the act step");

endmodule

/* rtl/kgt_store.sv */
module kgt_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kgt_pkg::t_wr                     i_wr,
    input  logic [kgt_pkg::IDX_W-1:0]        i_rd_idx,
    output kgt_pkg::t_entry                  o_rd,
    output logic                             o_rd_valid,
    output logic [kgt_pkg::TABLE_DEPTH-1:0]  o_valid
);

    logic [kgt_pkg::KEY_W-1:0]  r_key   [kgt_pkg::TABLE_DEPTH];
    logic [kgt_pkg::GAIN_W-1:0] r_gain  [kgt_pkg::TABLE_DEPTH];
    logic                       r_mute  [kgt_pkg::TABLE_DEPTH];
    logic [kgt_pkg::TIME_W-1:0] r_stamp [kgt_pkg::TABLE_DEPTH];
    logic [kgt_pkg::TABLE_DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= 1'b1;
        end else if (i_wr.clr) begin
            r_valid[i_wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key[i_wr.idx]   <= i_wr.data.key;
            r_gain[i_wr.idx]  <= i_wr.data.gain;
            r_mute[i_wr.idx]  <= i_wr.data.mute;
            r_stamp[i_wr.idx] <= i_wr.data.stamp;
        end
    end

    // an entry that is not valid reads as key 0, unity gain, unmuted and time 0
    always_comb begin
        o_rd_valid = r_valid[i_rd_idx];
        if (o_rd_valid) begin
            o_rd.key   = r_key[i_rd_idx];
            o_rd.gain  = r_gain[i_rd_idx];
            o_rd.mute  = r_mute[i_rd_idx];
            o_rd.stamp = r_stamp[i_rd_idx];
        end else begin
            o_rd.key   = '0;
            o_rd.gain  = kgt_pkg::UNITY_GAIN;
            o_rd.mute  = 1'b0;
            o_rd.stamp = '0;
        end
    end

    assign o_valid = r_valid;

endmodule

/* rtl/kgt_cmp.sv */
module kgt_cmp (
    input  kgt_pkg::t_entry             i_entry,
    input  logic                        i_entry_valid,
    input  logic [kgt_pkg::KEY_W-1:0]   i_key,
    input  logic [kgt_pkg::TIME_W-1:0]  i_best_time,
    output kgt_pkg::t_cmp               o_res
);

    assign o_res.match = i_entry_valid && (i_entry.key == i_key);
    assign o_res.older = i_entry.stamp < i_best_time;

endmodule
